// ----- hw/rtl/kwm_pkg.sv -----
package kwm_pkg;

    // Fixed field widths of the ports
    localparam int LANE_W = 3;   // lane / source_lane
    localparam int CFG_W  = 4;   // lane_count register

    localparam logic [CFG_W-1:0] LANE_COUNT_RESET = CFG_W'(8);

endpackage

// ----- hw/rtl/kwm_fifo.sv -----
module kwm_fifo
    import kwm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             wr_fire;
    logic             rd_fire;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign wr_fire = wr_en && !full;
    assign rd_fire = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (rd_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({wr_fire, rd_fire})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hw/rtl/kwm_front.sv -----
module kwm_front
    import kwm_pkg::*;
#(
    parameter int LANES       = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int LW          = $clog2(LANES),
    parameter int QW          = VALUE_WIDTH + LW + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [LANE_W-1:0]             lane,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          lane_end,
    input  logic [CFG_W-1:0]              lane_count,
    input  logic                          q_pop,
    output logic [QW-1:0]                 q_data,
    output logic                          q_empty
);

    logic          lane_ok;
    logic [LW-1:0] lane_idx;
    logic [QW-1:0] entry;

    // lane must be below both the programmed count and the lane storage
    assign lane_ok  = ({1'b0, lane} < {1'b0, lane_count}) && (int'(lane) < LANES);
    assign lane_idx = LW'(lane);
    // entry: {apply, lane index, end marker, value}
    assign entry    = {lane_ok, lane_idx, lane_end, value};

    kwm_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (entry),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

endmodule

// ----- hw/rtl/kwm_back.sv -----
module kwm_back
    import kwm_pkg::*;
#(
    parameter int LANES       = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int LW          = $clog2(LANES),
    parameter int QW          = VALUE_WIDTH + LW + 2,
    parameter int OW          = VALUE_WIDTH + LANE_W + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] lane_count,
    input  logic [QW-1:0]    q_data,
    input  logic             q_empty,
    output logic             q_pop,
    input  logic             o_full,
    output logic             o_push,
    output logic [OW-1:0]    o_data
);

    localparam int VW  = VALUE_WIDTH;
    localparam int PAD = 1 << LW;

    logic signed [VW-1:0] head_value_reg [LANES];
    logic [LANES-1:0]     head_valid_reg, head_valid_next;
    logic [LANES-1:0]     lane_finished_reg, lane_finished_next;
    logic                 merge_over_reg, merge_over_next;

    logic                 step;
    logic                 take;
    logic                 wr_head;
    logic                 q_apply;
    logic [LW-1:0]        q_lane;
    logic                 q_end;
    logic signed [VW-1:0] q_value;

    logic [LANES-1:0]     active;
    logic [LANES-1:0]     valid_mid;
    logic [LANES-1:0]     fin_mid;
    logic                 all_ready;

    logic                 node_vld [2*PAD];
    logic signed [VW-1:0] node_key [2*PAD];
    logic [LW-1:0]        node_idx [2*PAD];

    assign q_value = q_data[VW-1:0];
    assign q_end   = q_data[VW];
    assign q_lane  = q_data[VW+LW:VW+1];
    assign q_apply = q_data[VW+LW+1];

    assign step    = !q_empty && !o_full;
    assign q_pop   = step;
    assign take    = step && !merge_over_reg && q_apply
                     && !head_valid_reg[q_lane] && !lane_finished_reg[q_lane];
    assign wr_head = take && !q_end;

    // lane state with this item folded in
    always_comb
    begin
        valid_mid = head_valid_reg;
        fin_mid   = lane_finished_reg;
        if (take)
        begin
            if (q_end)
            begin
                fin_mid[q_lane] = 1'b1;
            end
            else
            begin
                valid_mid[q_lane] = 1'b1;
            end
        end
        all_ready = 1'b1;
        for (int i = 0; i < LANES; i++)
        begin
            active[i] = (i < int'(lane_count));
            if (active[i] && !valid_mid[i] && !fin_mid[i])
            begin
                all_ready = 1'b0;
            end
        end
    end

    // min tree over active heads; left wins ties so the lower lane is picked
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            node_vld[PAD+i] = valid_mid[i] && active[i];
            node_key[PAD+i] = (wr_head && (q_lane == LW'(i))) ? q_value : head_value_reg[i];
            node_idx[PAD+i] = LW'(i);
        end
        for (int i = LANES; i < PAD; i++)
        begin
            node_vld[PAD+i] = 1'b0;
            node_key[PAD+i] = '0;
            node_idx[PAD+i] = '0;
        end
        node_vld[0] = 1'b0;
        node_key[0] = '0;
        node_idx[0] = '0;
        for (int n = PAD - 1; n >= 1; n--)
        begin
            if (node_vld[2*n] && (!node_vld[2*n+1] || (node_key[2*n] <= node_key[2*n+1])))
            begin
                node_vld[n] = 1'b1;
                node_key[n] = node_key[2*n];
                node_idx[n] = node_idx[2*n];
            end
            else
            begin
                node_vld[n] = node_vld[2*n+1];
                node_key[n] = node_key[2*n+1];
                node_idx[n] = node_idx[2*n+1];
            end
        end
    end

    always_comb
    begin
        head_valid_next    = head_valid_reg;
        lane_finished_next = lane_finished_reg;
        merge_over_next    = merge_over_reg;
        o_push             = step && !merge_over_reg && all_ready;
        o_data             = '0;
        if (step)
        begin
            head_valid_next    = valid_mid;
            lane_finished_next = fin_mid;
        end
        if (o_push)
        begin
            if (node_vld[1])
            begin
                head_valid_next[node_idx[1]] = 1'b0;
                o_data = {1'b0, LANE_W'(node_idx[1]), node_key[1]};
            end
            else
            begin
                merge_over_next = 1'b1;
                o_data = {1'b1, {LANE_W{1'b0}}, {VW{1'b0}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg    <= '0;
            lane_finished_reg <= '0;
            merge_over_reg    <= 1'b0;
        end
        else
        begin
            head_valid_reg    <= head_valid_next;
            lane_finished_reg <= lane_finished_next;
            merge_over_reg    <= merge_over_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_head)
        begin
            head_value_reg[q_lane] <= q_value;
        end
    end

endmodule

// ----- hw/rtl/k_way_sorted_merge.sv -----
// k-way sorted merge. Feed it elements of up to lane_count ascending lanes of
// signed values, each tagged with its lane, or an end marker for a lane; it
// returns one ascending stream, each element tagged with the lane it came from,
// which is the lane whose next element it wants. Once every active lane holds a
// head or has ended, the smallest head goes out (ties to the lowest lane); when
// all active lanes have ended, one done item goes out and everything after it is
// ignored until reset. Inputs for inactive, already full or already ended lanes
// are dropped. Throughput is one input transfer per clock while the result
// queue is not full; a result is written into the output queue as its input
// transfer leaves the input queue and can be popped from the next clock on. The
// transfer waits in the input queue; the head update and min-select run
// combinationally as it leaves that queue, and their comparator tree over LANES
// heads sets the clock period. Both sides have two-entry queues, so push and
// pop stall independently. Write lane_count only while the block is idle.
module k_way_sorted_merge
    import kwm_pkg::*;
#(
    parameter int LANES       = 8,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    // input queue side
    input  logic                          push,
    output logic                          full,
    input  logic [LANE_W-1:0]             lane,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          lane_end,

    // result queue side
    output logic                          empty,
    input  logic                          pop,
    output logic signed [VALUE_WIDTH-1:0] out_value,
    output logic [LANE_W-1:0]             source_lane,
    output logic                          done_res,

    // lane_count write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              cfg_data
);

    localparam int LW = $clog2(LANES);
    localparam int QW = VALUE_WIDTH + LW + 2;
    localparam int OW = VALUE_WIDTH + LANE_W + 1;

    logic [CFG_W-1:0] lane_count_reg;

    logic [QW-1:0]    q_data;
    logic             q_empty;
    logic             q_pop;

    logic [OW-1:0]    o_data;
    logic             o_push;
    logic             o_full;
    logic [OW-1:0]    r_data;

    // lane_count: values above LANES behave as LANES
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_count_reg <= LANE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lane_count_reg <= cfg_data;
        end
    end

    // front: tags each transfer with whether its lane is in range, then queues it
    kwm_front #(
        .LANES       (LANES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .LW          (LW),
        .QW          (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .lane       (lane),
        .value      (value),
        .lane_end   (lane_end),
        .lane_count (lane_count_reg),
        .q_pop      (q_pop),
        .q_data     (q_data),
        .q_empty    (q_empty)
    );

    // back: head table, min-select, done detection
    kwm_back #(
        .LANES       (LANES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .LW          (LW),
        .QW          (QW),
        .OW          (OW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_count (lane_count_reg),
        .q_data     (q_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .o_full     (o_full),
        .o_push     (o_push),
        .o_data     (o_data)
    );

    // result queue: {done, lane, value}
    kwm_fifo #(
        .WIDTH (OW),
        .DEPTH (2)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_push),
        .wr_data (o_data),
        .full    (o_full),
        .rd_en   (pop),
        .rd_data (r_data),
        .empty   (empty)
    );

    assign out_value   = r_data[VALUE_WIDTH-1:0];
    assign source_lane = r_data[VALUE_WIDTH+LANE_W-1:VALUE_WIDTH];
    assign done_res    = r_data[OW-1];

endmodule
